@@ src/assert_macros.svh @@
// assertion macros used by the top level rtl file of the region configuration block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, idle during reset
`define DRCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, idle during reset
`define DRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DRCC_ASSERT_NOW(lbl, ante, cons, msg)
`define DRCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/drcc_pkg.sv @@
// types and constants of the dram region configuration pipeline
`timescale 1ns / 1ps
package drcc_pkg;

  localparam int unsigned GEO_W  = 4;
  localparam int unsigned EXP_W  = 5;
  localparam int unsigned CODE_W = 3;

  localparam logic [GEO_W-1:0] GEO_10 = 4'd10;
  localparam logic [GEO_W-1:0] GEO_11 = 4'd11;
  localparam logic [GEO_W-1:0] GEO_12 = 4'd12;

  // log2 of bytes for codes 1..7 (2 MiB .. 128 MiB)
  localparam logic [EXP_W-1:0] EXP_MIN  = 5'd21;
  localparam logic [EXP_W-1:0] EXP_MAX  = 5'd27;
  localparam logic [EXP_W-1:0] EXP_BASE = 5'd20;
  localparam logic [EXP_W-1:0] EXP_WORD = 5'd2;

  typedef struct packed {
    logic [3:0] bank0_col_bits;
    logic [3:0] bank0_row_bits;
    logic       bank0_two_sided;
    logic [3:0] bank1_col_bits;
    logic [3:0] bank1_row_bits;
    logic       bank1_two_sided;
    logic [3:0] bank2_col_bits;
    logic [3:0] bank2_row_bits;
    logic       bank2_two_sided;
    logic [3:0] bank3_col_bits;
    logic [3:0] bank3_row_bits;
    logic       bank3_two_sided;
  } in_t;

  typedef struct packed {
    logic [6:0] region_size_byte;
    logic [5:0] region_layout_byte;
    logic [1:0] ma11_need;
  } out_t;

  // one bank after sanitizing, with its size exponent (0 = absent)
  typedef struct packed {
    logic [GEO_W-1:0] cols;
    logic [GEO_W-1:0] rows;
    logic             two;
    logic [EXP_W-1:0] expo;
  } bank_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              pair;
    logic              ds;
    logic              alone_second;
    logic              ma11;
  } region_t;

endpackage

@@ src/drcc_sanitize.sv @@
// first stage logic: bank geometry check and size exponent
`timescale 1ns / 1ps
module drcc_sanitize
  import drcc_pkg::*;
(
  input  logic [GEO_W-1:0] col_bits,
  input  logic [GEO_W-1:0] row_bits,
  input  logic             two_sided,
  output bank_t            bank
);

  logic ok;
  logic present;

  // supported column x row pairs, or an empty slot
  always_comb begin
    ok = 1'b0;
    case (col_bits)
      4'd0:   ok = (row_bits == 4'd0);
      GEO_10: ok = row_bits inside {GEO_10, GEO_11, GEO_12};
      GEO_11: ok = row_bits inside {GEO_11, GEO_12};
      GEO_12: ok = (row_bits == GEO_12);
      default: ok = 1'b0;
    endcase
  end

  // unsupported banks read as empty and single sided
  assign present = ok && (col_bits != 4'd0);

  always_comb begin
    bank.cols = ok ? col_bits : '0;
    bank.rows = ok ? row_bits : '0;
    bank.two  = ok && two_sided;
    bank.expo = present ?
                (EXP_W'(col_bits) + EXP_W'(row_bits) + EXP_WORD + EXP_W'(two_sided)) :
                '0;
  end

endmodule

@@ src/drcc_unify.sv @@
// second stage logic: merge two sanitized banks into one region
`timescale 1ns / 1ps
module drcc_unify
  import drcc_pkg::*;
(
  input  bank_t   lo,
  input  bank_t   hi,
  output region_t region
);

  logic [GEO_W-1:0] t_cols;
  logic [GEO_W-1:0] t_rows;
  logic             t_two;
  logic [EXP_W-1:0] ec;

  function automatic logic [CODE_W-1:0] exp_to_code(input logic [EXP_W-1:0] e);
    logic [EXP_W-1:0] d;
    d = e - EXP_BASE;
    if (e >= EXP_MIN && e <= EXP_MAX) return d[CODE_W-1:0];
    return '0;
  endfunction

  // common denominator of both banks, doubled
  assign t_cols = (lo.cols < hi.cols) ? lo.cols : hi.cols;
  assign t_rows = (lo.rows < hi.rows) ? lo.rows : hi.rows;
  assign t_two  = lo.two && hi.two;
  assign ec     = EXP_W'(t_cols) + EXP_W'(t_rows) + EXP_WORD + EXP_W'(t_two) + 5'd1;

  // pick one bank alone, the pair, or nothing
  always_comb begin
    region = '0;
    if (lo.expo == '0 && hi.expo == '0) begin
      region = '0;
    end else if (lo.expo == '0 || (hi.expo != '0 && lo.expo <= ec && hi.expo > ec)) begin
      region.code         = exp_to_code(hi.expo);
      region.ds           = hi.two;
      region.alone_second = 1'b1;
      region.ma11         = (hi.rows == GEO_12);
    end else if (hi.expo == '0 || lo.expo > ec) begin
      region.code = exp_to_code(lo.expo);
      region.ds   = lo.two;
      region.ma11 = (lo.rows == GEO_12);
    end else begin
      region.code = exp_to_code(ec);
      region.ds   = t_two;
      region.pair = 1'b1;
      region.ma11 = (t_rows == GEO_12);
    end
  end

endmodule

@@ src/drcc_pack.sv @@
// third stage logic: order the regions and pack the controller bytes
`timescale 1ns / 1ps
module drcc_pack
  import drcc_pkg::*;
(
  input  region_t g0,
  input  region_t g1,
  output out_t    result
);

  logic    swap;
  region_t up;
  region_t lw;

  // region 1 with the larger code sets the swap flag
  assign swap = g1.code > g0.code;
  assign up   = swap ? g0 : g1;
  assign lw   = swap ? g1 : g0;

  always_comb begin
    result.region_size_byte   = {up.code, swap, lw.code};
    result.region_layout_byte = {up.alone_second, lw.alone_second,
                                 up.ds, up.pair, lw.ds, lw.pair};
    result.ma11_need          = {up.ma11, lw.ma11};
  end

endmodule

@@ src/dram_region_config_calc.sv @@
// top level: three stage pipeline computing the dram region configuration
//
// Usage:
//   in_valid/in_ready/in_data carry one transaction with the geometry of four
//   banks (column bits, row bits, sidedness). out_valid/out_ready/out_data
//   return one transaction per input with the packed size byte, layout byte
//   and MA11 flags.
//   From input acceptance to out_valid a transaction passes the sanitize
//   register, region register and packed output register.
//   Throughput: one transaction per cycle unless out_ready stalls; a stage
//   register takes a new transaction when empty or its successor moves on.
//   Reset (rst_n low, synchronous) empties all stages; no result is pending.
//   When the receiver stalls, the output register holds its transaction and
//   earlier stages keep filling until all three are occupied, then in_ready
//   falls; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dram_region_config_calc
  import drcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  bank_t   bank_nxt [4];
  bank_t   bank_r   [4];
  region_t reg_nxt  [2];
  region_t reg_r    [2];
  out_t    res_nxt;
  out_t    res_r;
  logic    v1_r, v2_r, v3_r;
  logic    en1, en2, en3;

  // per-stage advance: a stage loads when empty or when it drains forward
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: sanitize each bank
  drcc_sanitize u_san0 (.col_bits(in_data.bank0_col_bits), .row_bits(in_data.bank0_row_bits),
                        .two_sided(in_data.bank0_two_sided), .bank(bank_nxt[0]));
  drcc_sanitize u_san1 (.col_bits(in_data.bank1_col_bits), .row_bits(in_data.bank1_row_bits),
                        .two_sided(in_data.bank1_two_sided), .bank(bank_nxt[1]));
  drcc_sanitize u_san2 (.col_bits(in_data.bank2_col_bits), .row_bits(in_data.bank2_row_bits),
                        .two_sided(in_data.bank2_two_sided), .bank(bank_nxt[2]));
  drcc_sanitize u_san3 (.col_bits(in_data.bank3_col_bits), .row_bits(in_data.bank3_row_bits),
                        .two_sided(in_data.bank3_two_sided), .bank(bank_nxt[3]));

  // stage 2: merge bank pairs into regions
  drcc_unify u_uni0 (.lo(bank_r[0]), .hi(bank_r[1]), .region(reg_nxt[0]));
  drcc_unify u_uni1 (.lo(bank_r[2]), .hi(bank_r[3]), .region(reg_nxt[1]));

  // stage 3: order and pack
  drcc_pack u_pack (.g0(reg_r[0]), .g1(reg_r[1]), .result(res_nxt));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) bank_r <= bank_nxt;
    if (en2) reg_r  <= reg_nxt;
    if (en3) res_r  <= res_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = res_r;

  // checks
  `DRCC_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v1_r, "accepted transaction lost at stage 1")
  `DRCC_ASSERT_NEXT(a_mid_hold, v2_r && !en3, v2_r && $stable(reg_r[0]) && $stable(reg_r[1]), "stage 2 changed while stalled")
  `DRCC_ASSERT_NOW(a_swap_order, out_valid && out_data.region_size_byte[3], out_data.region_size_byte[2:0] > out_data.region_size_byte[6:4], "swap flag without larger second region")
  `DRCC_ASSERT_NOW(a_pair_alone, out_valid, !(out_data.region_layout_byte[5] && out_data.region_layout_byte[2]) && !(out_data.region_layout_byte[4] && out_data.region_layout_byte[0]), "region both paired and single")

endmodule

@@ dv/tb_dram_region_config_calc.sv @@
// testbench for dram_region_config_calc: predicts region config bytes and checks every transaction
`timescale 1ns / 1ps
module tb_dram_region_config_calc;
  import drcc_pkg::*;

  localparam int unsigned RAND_ITEMS   = 1400;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned BURST_LO     = 700;
  localparam int unsigned BURST_HI     = 900;
  localparam int unsigned DRAIN_CYCLES = 8;

  // predicts the packed controller bytes for each bank set and compares results
  class region_cfg_checker;
    typedef struct packed {
      logic [3:0] cols;
      logic [3:0] rows;
      logic       two;
    } geo_t;

    typedef struct packed {
      logic [2:0] code;
      logic       pair;
      logic       ds;
      logic       alone_second;
      logic       ma11;
    } span_t;

    out_t        expected_cfgs[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // unsupported column/row pairs disable the bank
    function geo_t clean_geo(logic [3:0] c, logic [3:0] r, logic two);
      geo_t g;
      bit   ok;
      ok = (c == 4'd0 && r == 4'd0) ||
           (c == GEO_10 && (r == GEO_10 || r == GEO_11 || r == GEO_12)) ||
           (c == GEO_11 && (r == GEO_11 || r == GEO_12)) ||
           (c == GEO_12 && r == GEO_12);
      g.cols = ok ? c : 4'd0;
      g.rows = ok ? r : 4'd0;
      g.two  = ok ? two : 1'b0;
      return g;
    endfunction

    // log2 of bank bytes, 0 when absent
    function int unsigned size_exp(geo_t g);
      if (g.cols == 0 || g.rows == 0) return 0;
      return g.cols + g.rows + EXP_WORD + g.two;
    endfunction

    function logic [2:0] exp_code(int unsigned e);
      if (e >= EXP_MIN && e <= EXP_MAX) return 3'(e - EXP_BASE);
      return 3'd0;
    endfunction

    function span_t lone(geo_t g, int unsigned e, bit second);
      span_t s;
      s.code         = exp_code(e);
      s.ds           = g.two;
      s.pair         = 1'b0;
      s.alone_second = second;
      s.ma11         = (g.rows == GEO_12);
      return s;
    endfunction

    // common denominator of both banks, the larger bank alone, or nothing when both are absent
    function span_t merge_banks(geo_t lo, geo_t hi);
      span_t       s;
      geo_t        t;
      int unsigned el, eh, ec;
      s  = '0;
      el = size_exp(lo);
      eh = size_exp(hi);
      if (el == 0 && eh == 0) return s;
      if (el == 0) return lone(hi, eh, 1'b1);
      if (eh == 0) return lone(lo, el, 1'b0);
      t.cols = (lo.cols < hi.cols) ? lo.cols : hi.cols;
      t.rows = (lo.rows < hi.rows) ? lo.rows : hi.rows;
      t.two  = lo.two && hi.two;
      ec     = size_exp(t) + 1;
      if (el > ec) return lone(lo, el, 1'b0);
      if (eh > ec) return lone(hi, eh, 1'b1);
      s.code = exp_code(ec);
      s.ds   = t.two;
      s.pair = 1'b1;
      s.ma11 = (t.rows == GEO_12);
      return s;
    endfunction

    function out_t predict_region_cfg(in_t d);
      out_t  o;
      span_t r0, r1, up, lw;
      bit    swap;
      r0 = merge_banks(clean_geo(d.bank0_col_bits, d.bank0_row_bits, d.bank0_two_sided),
                       clean_geo(d.bank1_col_bits, d.bank1_row_bits, d.bank1_two_sided));
      r1 = merge_banks(clean_geo(d.bank2_col_bits, d.bank2_row_bits, d.bank2_two_sided),
                       clean_geo(d.bank3_col_bits, d.bank3_row_bits, d.bank3_two_sided));
      // larger code goes lower, ties keep region 0 lower
      swap = r1.code > r0.code;
      up   = swap ? r0 : r1;
      lw   = swap ? r1 : r0;
      o.region_size_byte   = {up.code, swap, lw.code};
      o.region_layout_byte = {up.alone_second, lw.alone_second, up.ds, up.pair, lw.ds, lw.pair};
      o.ma11_need          = {up.ma11, lw.ma11};
      return o;
    endfunction

    function void note_bank_set(in_t d);
      expected_cfgs.push_back(predict_region_cfg(d));
    endfunction

    function void check_cfg(out_t got);
      out_t want;
      if (expected_cfgs.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_cfgs.pop_front();
      if (got.region_size_byte !== want.region_size_byte) begin
        $error("region_size_byte: expected %h, got %h",
               want.region_size_byte, got.region_size_byte);
        errors++;
      end
      if (got.region_layout_byte !== want.region_layout_byte) begin
        $error("region_layout_byte: expected %h, got %h",
               want.region_layout_byte, got.region_layout_byte);
        errors++;
      end
      if (got.ma11_need !== want.ma11_need) begin
        $error("ma11_need: expected %h, got %h", want.ma11_need, got.ma11_need);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_cfgs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  region_cfg_checker cfg_chk;
  int unsigned       in_count = 0;

  dram_region_config_calc dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one bank's fields in in_t order
  function automatic logic [8:0] bank_geo(logic [3:0] c, logic [3:0] r, logic two);
    return {c, r, two};
  endfunction

  // mostly supported geometry or empty, sometimes raw field values
  function automatic logic [8:0] random_bank(bit well_formed);
    logic [3:0] c, r;
    case ($urandom_range(6))
      0: begin c = 4'd0;  r = 4'd0;  end
      1: begin c = GEO_10; r = GEO_10; end
      2: begin c = GEO_10; r = GEO_11; end
      3: begin c = GEO_10; r = GEO_12; end
      4: begin c = GEO_11; r = GEO_11; end
      5: begin c = GEO_11; r = GEO_12; end
      default: begin c = GEO_12; r = GEO_12; end
    endcase
    if (!well_formed) begin
      c = 4'($urandom_range(15));
      r = 4'($urandom_range(15));
    end
    return bank_geo(c, r, 1'($urandom_range(1)));
  endfunction

  // monitor both channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cfg_chk.note_bank_set(in_data);
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) cfg_chk.check_cfg(out_data);
    end
  end

  // offer one bank set, optionally idling first, and wait for acceptance
  task automatic offer_bank_set(input in_t d, input bit may_idle);
    while (may_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (in_count >= BURST_LO && in_count < BURST_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL dram_region_config_calc");
    $finish;
  end

  // stimulus and end of test
  initial begin
    in_t directed_sets[$];
    in_t d;
    bit  well;
    cfg_chk  = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all empty, and all double sided 12x12 (256 MiB pair, code 0 with flags)
    directed_sets.push_back({4{bank_geo(4'd0, 4'd0, 1'b0)}});
    directed_sets.push_back({4{bank_geo(GEO_12, GEO_12, 1'b1)}});
    // each supported pair alone in bank 0
    directed_sets.push_back({bank_geo(GEO_10, GEO_10, 1'b0), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    directed_sets.push_back({bank_geo(GEO_10, GEO_11, 1'b1), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    directed_sets.push_back({bank_geo(GEO_10, GEO_12, 1'b0), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    directed_sets.push_back({bank_geo(GEO_11, GEO_11, 1'b1), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    directed_sets.push_back({bank_geo(GEO_11, GEO_12, 1'b0), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    directed_sets.push_back({bank_geo(GEO_12, GEO_12, 1'b1), {3{bank_geo(4'd0, 4'd0, 1'b0)}}});
    // second bank alone in each region
    directed_sets.push_back({bank_geo(4'd0, 4'd0, 1'b1), bank_geo(GEO_11, GEO_12, 1'b1),
                             bank_geo(4'd0, 4'd0, 1'b0), bank_geo(GEO_10, GEO_10, 1'b0)});
    // a single bank larger than the pair, first then second
    directed_sets.push_back({bank_geo(GEO_12, GEO_12, 1'b1), bank_geo(GEO_10, GEO_10, 1'b0),
                             bank_geo(GEO_10, GEO_10, 1'b0), bank_geo(GEO_12, GEO_12, 1'b1)});
    // mixed sidedness and geometry in region 0 leave the first bank alone; region 1 is a matched pair
    directed_sets.push_back({bank_geo(GEO_11, GEO_12, 1'b1), bank_geo(GEO_11, GEO_11, 1'b0),
                             bank_geo(GEO_10, GEO_12, 1'b1), bank_geo(GEO_10, GEO_12, 1'b1)});
    // unsupported geometry disables banks
    directed_sets.push_back({bank_geo(4'd13, 4'd13, 1'b1), bank_geo(4'd15, 4'd15, 1'b1),
                             bank_geo(GEO_10, 4'd9, 1'b1), bank_geo(GEO_12, GEO_11, 1'b1)});
    directed_sets.push_back({bank_geo(4'd9, GEO_10, 1'b1), bank_geo(GEO_10, 4'd0, 1'b1),
                             bank_geo(4'd0, GEO_12, 1'b1), bank_geo(GEO_11, GEO_10, 1'b0)});
    directed_sets.push_back({4{bank_geo(4'hf, 4'hf, 1'b1)}});
    // equal size codes keep region 0 lower
    directed_sets.push_back({bank_geo(GEO_11, GEO_11, 1'b0), bank_geo(4'd0, 4'd0, 1'b0),
                             bank_geo(4'd0, 4'd0, 1'b0), bank_geo(GEO_10, GEO_12, 1'b0)});
    // region 1 larger forces a swap
    directed_sets.push_back({bank_geo(GEO_10, GEO_10, 1'b0), bank_geo(4'd0, 4'd0, 1'b0),
                             bank_geo(GEO_12, GEO_12, 1'b0), bank_geo(GEO_12, GEO_12, 1'b0)});
    // region 0 larger, no swap; smallest pair
    directed_sets.push_back({bank_geo(GEO_12, GEO_12, 1'b0), bank_geo(GEO_12, GEO_12, 1'b0),
                             bank_geo(GEO_10, GEO_10, 1'b0), bank_geo(GEO_10, GEO_10, 1'b0)});
    // empty region against a full one
    directed_sets.push_back({bank_geo(4'd0, 4'd0, 1'b0), bank_geo(4'd0, 4'd0, 1'b0),
                             bank_geo(GEO_11, GEO_12, 1'b1), bank_geo(GEO_11, GEO_12, 1'b1)});
    foreach (directed_sets[i]) offer_bank_set(directed_sets[i], 1'b1);

    // random bank sets, mostly supported geometry
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      well = ($urandom_range(99) < 80);
      d = {random_bank(well), random_bank(well), random_bank(well), random_bank(well)};
      offer_bank_set(d, !(in_count >= BURST_LO && in_count < BURST_HI));
    end
    in_valid <= 1'b0;

    // drain outstanding transactions
    while (cfg_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cfg_chk.errors == 0 && cfg_chk.pending() == 0) begin
      $display("PASS dram_region_config_calc");
    end else begin
      $display("FAIL dram_region_config_calc");
    end
    $finish;
  end

endmodule
